// ===== hw/rtl/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

  localparam int LEN_W       = 64;
  localparam int CMP_W       = (LEN_W > 32) ? LEN_W : 32;
  localparam int KEY_BYTES   = 4;
  localparam int EXT16_BYTES = 2;
  localparam int EXT64_BYTES = 8;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DEAD    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    K_DATA  = 2'd0,
    K_EMPTY = 2'd1,
    K_CLOSE = 2'd2,
    K_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    E_FRAG   = 2'd0,
    E_OPCODE = 2'd1,
    E_LONG   = 2'd2
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic [3:0] opcode;
    err_t       code;
  } wsdf_rec_t;

endpackage

// ===== hw/rtl/wsdf_front.sv =====
// Header parser: classifies stream bytes and produces result records.
module wsdf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_acc,
  input  logic [7:0]         in_byte,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_max_payload_len,
  output logic               rec_push,
  output wsdf_pkg::wsdf_rec_t rec
);
  import wsdf_pkg::*;

  phase_t            phase_r,  phase_nxt;
  logic [3:0]        opcode_r, opcode_nxt;
  logic              masked_r, masked_nxt;
  logic              skip_r,   skip_nxt;
  logic              ovf_r,    ovf_nxt;
  logic [3:0][7:0]   key_r,    key_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic [3:0]        cnt_r,    cnt_nxt;
  logic [1:0]        off_r,    off_nxt;
  logic [31:0]       max_r;

  logic              lk_go, lk_ovf, lk_skip, lk_masked;
  logic [LEN_W-1:0]  lk_len;
  logic              sp_go, sp_skip;
  logic [LEN_W-1:0]  sp_len;
  logic              close_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_r <= cfg_max_payload_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      skip_r   <= 1'b0;
      ovf_r    <= 1'b0;
      key_r    <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      off_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      skip_r   <= skip_nxt;
      ovf_r    <= ovf_nxt;
      key_r    <= key_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      off_r    <= off_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    skip_nxt   = skip_r;
    ovf_nxt    = ovf_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    off_nxt    = off_r;
    rec_push   = 1'b0;
    rec.kind   = K_DATA;
    rec.data   = 8'h00;
    rec.key    = 8'h00;
    rec.last   = 1'b0;
    rec.code   = E_FRAG;
    lk_go      = 1'b0;
    lk_len     = len_r;
    lk_ovf     = ovf_r;
    lk_skip    = skip_r;
    lk_masked  = masked_r;
    sp_go      = 1'b0;
    sp_len     = len_r;
    sp_skip    = skip_r;
    close_hit  = 1'b0;

    if (in_acc) begin
      case (phase_r)
        PH_HDR0: begin
          opcode_nxt = in_byte[3:0];
          skip_nxt   = 1'b0;
          ovf_nxt    = 1'b0;
          if (!in_byte[7]) begin
            phase_nxt = PH_DEAD;
            rec_push  = 1'b1;
            rec.kind  = K_ERROR;
            rec.code  = E_FRAG;
          end else if (!(in_byte[3:0] inside {OP_TEXT, OP_BINARY, OP_CLOSE})) begin
            phase_nxt = PH_DEAD;
            rec_push  = 1'b1;
            rec.kind  = K_ERROR;
            rec.code  = E_OPCODE;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_nxt = in_byte[7];
          close_hit  = (opcode_r == OP_CLOSE) || (in_byte[6:0] == 7'd0);
          if (close_hit) begin
            skip_nxt = 1'b1;
            rec_push = 1'b1;
            rec.kind = K_CLOSE;
          end
          if (in_byte[6:0] >= LEN7_EXT16) begin
            len_nxt   = '0;
            cnt_nxt   = (in_byte[6:0] == LEN7_EXT64) ? 4'(EXT64_BYTES) : 4'(EXT16_BYTES);
            phase_nxt = PH_EXTLEN;
          end else begin
            len_nxt   = LEN_W'(in_byte[6:0]);
            lk_go     = 1'b1;
            lk_len    = LEN_W'(in_byte[6:0]);
            lk_ovf    = ovf_r;
            lk_skip   = close_hit | skip_r;
            lk_masked = in_byte[7];
          end
        end
        PH_EXTLEN: begin
          ovf_nxt = ovf_r | (|len_r[LEN_W-1 -: 8]);
          len_nxt = ovf_nxt ? '1 : {len_r[LEN_W-9:0], in_byte};
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_nxt == 4'd0) begin
            lk_go  = 1'b1;
            lk_len = len_nxt;
            lk_ovf = ovf_nxt;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[2:0], in_byte};
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'(KEY_BYTES - 1)) begin
            cnt_nxt = '0;
            sp_go   = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          off_nxt = off_r + 2'd1;
          len_nxt = len_r - LEN_W'(1);
          if (len_r == LEN_W'(1)) begin
            phase_nxt = PH_HDR0;
          end
          if (!skip_r) begin
            rec_push = 1'b1;
            rec.kind = K_DATA;
            rec.data = in_byte;
            rec.key  = masked_r ? key_r[2'd3 - off_r] : 8'h00;
            rec.last = (len_r == LEN_W'(1));
          end
        end
        default: begin
        end
      endcase
    end

    if (lk_go) begin
      if (!lk_skip && (lk_ovf || (CMP_W'(lk_len) > CMP_W'(max_r)))) begin
        phase_nxt = PH_DEAD;
        rec_push  = 1'b1;
        rec.kind  = K_ERROR;
        rec.code  = E_LONG;
      end else if (lk_masked) begin
        key_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_KEY;
      end else begin
        sp_go   = 1'b1;
        sp_len  = lk_len;
        sp_skip = lk_skip;
      end
    end

    if (sp_go) begin
      off_nxt = '0;
      if (sp_len == '0) begin
        phase_nxt = PH_HDR0;
        if (!sp_skip) begin
          rec_push = 1'b1;
          rec.kind = K_EMPTY;
        end
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end

    rec.opcode = opcode_nxt;
  end

  a_dead_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |=> phase_r == PH_DEAD)
    else $error("left dead state without reset");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> len_r != '0)
    else $error("payload phase with zero remaining length");

  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |-> !rec_push)
    else $error("result produced after error");

endmodule

// ===== hw/rtl/wsdf_queue.sv =====
// Short record queue between the parser and the output stage.
module wsdf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsdf_pkg::wsdf_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                vld,
  output wsdf_pkg::wsdf_rec_t head
);
  import wsdf_pkg::*;

  wsdf_rec_t         mem [QDEPTH];
  logic [QAW-1:0]    wr_r, wr_nxt;
  logic [QAW-1:0]    rd_r, rd_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;

  assign full = (cnt_r == QCW'(QDEPTH));
  assign vld  = (cnt_r != '0);
  assign head = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QAW'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + QAW'(1) : rd_r;
    cnt_nxt = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !vld))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue count above depth");

endmodule

// ===== hw/rtl/wsdf_back.sv =====
// Output stage: unmasks payload bytes and holds the result for transfer.
module wsdf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  wsdf_pkg::wsdf_rec_t q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output wsdf_pkg::wsdf_rec_t out_rec
);
  import wsdf_pkg::*;

  logic      vld_r, vld_nxt;
  wsdf_rec_t rec_r, rec_nxt;
  logic      load;

  assign load      = q_vld && (!vld_r || out_pop);
  assign q_pop     = load;
  assign out_empty = !vld_r;
  assign out_rec   = rec_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_comb begin
    rec_nxt      = q_head;
    rec_nxt.data = q_head.data ^ q_head.key;
    rec_nxt.key  = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_nxt;
    end
  end

  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> vld_r)
    else $error("output register empty after load");

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Top level of the WebSocket receive-side frame deframer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   input    | in_push / in_full    | in_byte
//   result   | out_empty / out_pop  | out_result_kind, out_payload_byte,
//            |                      | out_last_of_frame, out_frame_opcode,
//            |                      | out_error_code
//   config   | cfg_we               | cfg_max_payload_len
//
// One byte is taken per cycle while in_full is low; the parser decides a byte's
// result in the cycle it is taken, the result enters the queue at that edge and is
// loaded into the output register at the next edge at the earliest. A four-entry
// queue and the output register absorb result stalls; in_full rises only when the
// queue is full. Reset is synchronous and active low; after an error the parser
// ignores all bytes until reset.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_frame,
  output logic [3:0]  out_frame_opcode,
  output logic [1:0]  out_error_code,
  input  logic        cfg_we,
  input  logic [31:0] cfg_max_payload_len
);
  import wsdf_pkg::*;

  logic      in_acc;
  logic      rec_push;
  wsdf_rec_t rec;
  logic      q_vld, q_pop;
  wsdf_rec_t q_head;
  wsdf_rec_t out_rec;

  assign in_acc = in_push && !in_full;

  wsdf_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_acc              (in_acc),
    .in_byte             (in_byte),
    .cfg_we              (cfg_we),
    .cfg_max_payload_len (cfg_max_payload_len),
    .rec_push            (rec_push),
    .rec                 (rec)
  );

  wsdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .full     (in_full),
    .pop      (q_pop),
    .vld      (q_vld),
    .head     (q_head)
  );

  wsdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_rec   (out_rec)
  );

  assign out_result_kind   = out_rec.kind;
  assign out_payload_byte  = out_rec.data;
  assign out_last_of_frame = out_rec.last;
  assign out_frame_opcode  = out_rec.opcode;
  assign out_error_code    = out_rec.code;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the WebSocket frame deframer: random frame streams checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import wsdf_pkg::*;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_BYTES    = 180;

  localparam int ENC_LEN7  = 0;
  localparam int ENC_EXT16 = 1;
  localparam int ENC_EXT64 = 2;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic [3:0] opcode;
    err_t       code;
  } frame_result_t;

  class ws_rx_scoreboard;
    logic [31:0]      max_len;
    phase_t           phase;
    logic [3:0]       opcode;
    bit               masked;
    bit               skip;
    bit               too_wide;
    logic [31:0]      key;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] offset;
    int unsigned      field_left;
    frame_result_t    pending_results[$];
    int unsigned      failures;

    function new();
      max_len    = MAX_LEN_RESET;
      phase      = PH_HDR0;
      opcode     = 4'h0;
      masked     = 1'b0;
      skip       = 1'b0;
      too_wide   = 1'b0;
      key        = '0;
      frame_len  = '0;
      offset     = '0;
      field_left = 0;
      failures   = 0;
    endfunction

    function void add(kind_t kind, logic [7:0] data, logic last, err_t code);
      frame_result_t r;
      r.kind   = kind;
      r.data   = data;
      r.last   = last;
      r.opcode = opcode;
      r.code   = code;
      pending_results.push_back(r);
    endfunction

    function void begin_payload();
      offset = '0;
      if (frame_len == 0) begin
        phase = PH_HDR0;
        if (!skip) add(K_EMPTY, 8'h00, 1'b0, E_FRAG);
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    function void length_done();
      if (!skip && (too_wide || frame_len > max_len)) begin
        phase = PH_DEAD;
        add(K_ERROR, 8'h00, 1'b0, E_LONG);
      end else if (masked) begin
        key        = '0;
        field_left = 0;
        phase      = PH_KEY;
      end else begin
        begin_payload();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [LEN_W+7:0] wide;
      logic [7:0]       data;
      bit               last;
      case (phase)
        PH_HDR0: begin
          opcode   = b[3:0];
          skip     = 1'b0;
          too_wide = 1'b0;
          if (!b[7]) begin
            phase = PH_DEAD;
            add(K_ERROR, 8'h00, 1'b0, E_FRAG);
          end else if (opcode != OP_TEXT && opcode != OP_BINARY && opcode != OP_CLOSE) begin
            phase = PH_DEAD;
            add(K_ERROR, 8'h00, 1'b0, E_OPCODE);
          end else begin
            phase = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked = b[7];
          if (opcode == OP_CLOSE || b[6:0] == 7'd0) begin
            skip = 1'b1;
            add(K_CLOSE, 8'h00, 1'b0, E_FRAG);
          end
          frame_len = '0;
          if (b[6:0] >= LEN7_EXT16) begin
            field_left = (b[6:0] == LEN7_EXT64) ? EXT64_BYTES : EXT16_BYTES;
            phase      = PH_EXTLEN;
          end else begin
            frame_len = LEN_W'(b[6:0]);
            length_done();
          end
        end
        PH_EXTLEN: begin
          wide = {frame_len, b};
          if (wide[LEN_W+7:LEN_W] != 0) too_wide = 1'b1;
          frame_len = too_wide ? '1 : wide[LEN_W-1:0];
          field_left--;
          if (field_left == 0) length_done();
        end
        PH_KEY: begin
          key = {key[23:0], b};
          field_left++;
          if (field_left == KEY_BYTES) begin
            field_left = 0;
            begin_payload();
          end
        end
        PH_PAYLOAD: begin
          last = ((offset + 1) == frame_len);
          data = masked ? (b ^ key[8*(3-offset[1:0]) +: 8]) : b;
          offset++;
          if (last) phase = PH_HDR0;
          if (!skip) add(K_DATA, data, last, E_FRAG);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last,
                               logic [3:0] op, logic [1:0] code);
      frame_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, byte %0h", kind, data);
        failures++;
      end else begin
        e = pending_results.pop_front();
        compare_field("result_kind", e.kind, kind);
        compare_field("payload_byte", e.data, data);
        compare_field("last_of_frame", e.last, last);
        compare_field("frame_opcode", e.opcode, op);
        compare_field("error_code", e.code, code);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_byte = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_payload_byte;
  logic        out_last_of_frame;
  logic [3:0]  out_frame_opcode;
  logic [1:0]  out_error_code;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_max_payload_len = MAX_LEN_RESET;

  ws_rx_scoreboard pred;
  logic [7:0]      frame_bytes[$];
  int unsigned     burst_left = 0;
  int unsigned     hold_req = 0;
  int unsigned     hold_ack = 0;
  int unsigned     hold_left = 0;
  int unsigned     pop_mode = 0;
  int unsigned     pop_span = 0;
  int unsigned     idle_cycles = 0;

  websocket_frame_deframer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_byte             (in_byte),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_result_kind     (out_result_kind),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_frame   (out_last_of_frame),
    .out_frame_opcode    (out_frame_opcode),
    .out_error_code      (out_error_code),
    .cfg_we              (cfg_we),
    .cfg_max_payload_len (cfg_max_payload_len)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      pred.check_result(out_result_kind, out_payload_byte, out_last_of_frame,
                        out_frame_opcode, out_error_code);
    end
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_pop   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else begin
      if (pop_span == 0) begin
        pop_mode <= $urandom_range(0, 3);
        pop_span <= $urandom_range(4, 120);
      end else begin
        pop_span <= pop_span - 1;
      end
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        2: out_pop <= ($urandom_range(0, 3) == 0);
        default: out_pop <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL websocket_frame_deframer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
    end
    in_push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pred.note_byte(b);
    burst_left--;
  endtask

  task automatic send_frame();
    while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front());
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    burst_left = 0;
    while (pred.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [31:0] v);
    cfg_we              <= 1'b1;
    cfg_max_payload_len <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred.max_len = v;
  endtask

  function automatic void put_frame(logic [3:0] op, bit m, logic [63:0] len, int enc,
                                    int unsigned npay);
    frame_bytes.push_back({1'b1, 3'($urandom_range(0, 7)), op});
    case (enc)
      ENC_LEN7: frame_bytes.push_back({m, len[6:0]});
      ENC_EXT16: begin
        frame_bytes.push_back({m, LEN7_EXT16});
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
      end
      default: begin
        frame_bytes.push_back({m, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[8*i +: 8]);
      end
    endcase
    if (m) repeat (KEY_BYTES) frame_bytes.push_back(8'($urandom()));
    repeat (npay) frame_bytes.push_back(8'($urandom()));
  endfunction

  function automatic void make_frame(logic [31:0] lim);
    int unsigned sel;
    int unsigned len;
    int          enc;
    logic [3:0]  op;
    bit          m;
    sel = $urandom_range(0, 99);
    m   = 1'($urandom_range(0, 1));
    op  = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 12);
    if (sel >= 85) begin
      op  = OP_CLOSE;
      len = $urandom_range(0, 20);
      enc = $urandom_range(ENC_LEN7, ENC_EXT64);
    end else if (sel >= 75) begin
      len = 0;
      enc = ENC_LEN7;
    end else if (sel >= 65 || lim == 0) begin
      len = 0;
      enc = $urandom_range(ENC_EXT16, ENC_EXT64);
    end else begin
      if (len > lim) len = lim;
      if (len > 125 || $urandom_range(0, 3) == 0) enc = $urandom_range(ENC_EXT16, ENC_EXT64);
      else enc = ENC_LEN7;
    end
    put_frame(op, m, 64'(len), enc, len);
  endfunction

  task automatic run_random_frames(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      make_frame(pred.max_len);
      sent += frame_bytes.size();
      send_frame();
    end
  endtask

  task automatic send_protocol_error();
    err_t        pick;
    logic [3:0]  op;
    logic [63:0] len;
    logic [31:0] lim;
    bit          m;
    pick = err_t'($urandom_range(0, 2));
    lim  = pred.max_len;
    m    = 1'($urandom_range(0, 1));
    case (pick)
      E_FRAG: frame_bytes.push_back(8'($urandom_range(0, 127)));
      E_OPCODE: begin
        do op = 4'($urandom_range(0, 15));
        while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE);
        frame_bytes.push_back({1'b1, 3'($urandom_range(0, 7)), op});
      end
      default: begin
        op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
        if (lim < 125 && $urandom_range(0, 1)) begin
          put_frame(op, m, 64'($urandom_range(lim + 1, 125)), ENC_LEN7, 0);
        end else if (lim < 65535 && $urandom_range(0, 1)) begin
          put_frame(op, m, 64'($urandom_range(lim + 1, 65535)), ENC_EXT16, 0);
        end else begin
          len = {$urandom(), $urandom()};
          len[63:56] = 8'($urandom_range(1, 255));
          put_frame(op, m, len, ENC_EXT64, 0);
        end
      end
    endcase
    send_frame();
  endtask

  initial begin
    logic [31:0] limits[5];
    pred = new();
    limits[0] = 32'hFFFF_FFFF;
    limits[1] = 32'h0;
    limits[2] = $urandom_range(1, 40);
    limits[3] = $urandom();
    limits[4] = 32'h1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    frame_bytes = '{8'hF1, 8'h82, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h5A,
                    8'h82, 8'h01, 8'hFF,
                    8'h88, 8'h00,
                    8'h81, 8'h00,
                    8'h82, 8'h7E, 8'h00, 8'h00,
                    8'h88, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
    send_frame();
    run_random_frames(PHASE_BYTES);

    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_max_len(limits[p]);
      if (p == 0) begin
        hold_req <= hold_req + 1;
        put_frame(OP_BINARY, 1'b0, 64'd60, ENC_LEN7, 60);
        send_frame();
      end
      run_random_frames(PHASE_BYTES);
    end

    drain_results();
    send_protocol_error();
    drain_results();
    write_max_len($urandom());
    repeat (12) frame_bytes.push_back(8'($urandom()));
    send_frame();
    drain_results();

    if (pred.failures == 0) $display("PASS websocket_frame_deframer");
    else $display("FAIL websocket_frame_deframer");
    $finish;
  end

endmodule
